@@ hdl/window_extreme_age_tracker_assert.svh @@
// assertion macros shared by the window extreme age tracker modules
`ifndef WINDOW_EXTREME_AGE_TRACKER_ASSERT_SVH
`define WINDOW_EXTREME_AGE_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define WEAT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weat assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define WEAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weat assertion failed");

`endif

@@ hdl/weat_pkg.sv @@
// shared constants and control types of the window extreme age tracker
package weat_pkg;

	// default window store depth
	localparam int DEFAULT_MAX_WINDOW = 64;

	// field and register widths
	localparam int SAMPLE_W = 32;
	localparam int OUT_W    = 6;
	localparam int WL_W     = 7;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTREME_KIND  = 1'b1;

	// register reset values
	localparam logic [WL_W-1:0] WL_RESET = 7'd14;
	localparam logic KIND_HIGH = 1'b0;
	localparam logic KIND_LOW  = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic scan_rd;
		logic load_out;
	} weat_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic out_free;
	} weat_status_t;

endpackage

@@ hdl/window_extreme_age_tracker.sv @@
// a word with no rescan goes from idle to done, where its result loads into the output register
// a rescan adds scan (n entries) and drain states; n the effective window length (1..MAX_WINDOW)
// the rescan reads one window store entry per cycle through the store's single read port
// the next word is taken while a result waits; a second result waits until the first is taken
// reset clears pointer, extreme, age and series flag; window_length 14, extreme_kind high
// the window store is not cleared at reset
module window_extreme_age_tracker import weat_pkg::*; #(
	parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       series_start,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [OUT_W-1:0]           samples_since_extreme
);

	weat_cmd_t    cmd;
	weat_status_t status;

	// controller
	weat_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	// datapath
	weat_dpath #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_wr_en            (cfg_wr_en),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.sample               (sample),
		.series_start         (series_start),
		.cmd                  (cmd),
		.status               (status),
		.out_ready            (out_ready),
		.out_valid            (out_valid),
		.samples_since_extreme(samples_since_extreme)
	);

endmodule

@@ hdl/weat_ram.sv @@
// generic single write, single read ram with registered read data
module weat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/weat_ctrl.sv @@
// controller state machine of the window extreme age tracker
module weat_ctrl import weat_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  weat_status_t status,
	output weat_cmd_t    cmd
);

`include "window_extreme_age_tracker_assert.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	// commands decoded from state
	always_comb begin
		cmd.accept   = in_valid && in_ready_q;
		cmd.scan_rd  = (state_q == S_SCAN);
		cmd.load_out = (state_q == S_DONE) && status.out_free;
	end

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= status.need_scan ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (status.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (status.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	// ready only when idle, and a word needing a rescan enters the scan
	`WEAT_ASSERT_SAME(a_ready_idle, in_ready_q, state_q == S_IDLE)
	`WEAT_ASSERT_NEXT(a_scan_entry, cmd.accept && status.need_scan, state_q == S_SCAN)

endmodule

@@ hdl/weat_dpath.sv @@
// datapath of the window extreme age tracker: registers, window store and compares
module weat_dpath import weat_pkg::*; #(
	parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       series_start,
	input  weat_cmd_t                  cmd,
	output weat_status_t               status,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [OUT_W-1:0]           samples_since_extreme
);

`include "window_extreme_age_tracker_assert.svh"

	localparam int ADDR_W = $clog2(MAX_WINDOW);
	localparam int AGE_W  = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W  = (AGE_W > WL_W) ? AGE_W : WL_W;
	localparam int D_W    = AGE_W + 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_WINDOW - 1);
	localparam logic [AGE_W-1:0]  AGE_MAX   = AGE_W'(MAX_WINDOW);

	// candidate replaces current extreme, ties go to the candidate
	function automatic logic takes_over(input logic kind, input logic signed [SAMPLE_W-1:0] cand,
		input logic signed [SAMPLE_W-1:0] cur);
		takes_over = (kind == KIND_LOW) ? (cand <= cur) : (cand >= cur);
	endfunction

	logic [WL_W-1:0]            wl_q;
	logic                       kind_q;
	logic [ADDR_W-1:0]          wi_q;
	logic signed [SAMPLE_W-1:0] ext_q;
	logic [AGE_W-1:0]           age_q;
	logic                       active_q;
	logic [ADDR_W-1:0]          scan_addr_q;
	logic [ADDR_W-1:0]          k_q;
	logic                       first_q;
	logic                       rd_valid_s1;
	logic [ADDR_W-1:0]          k_s1;
	logic                       first_s1;
	logic                       out_valid_q;
	logic [OUT_W-1:0]           out_q;

	logic signed [SAMPLE_W-1:0] rd_data;
	logic [AGE_W-1:0]           n;
	logic [CMP_W-1:0]           wl_ext;
	logic                       restart;
	logic                       take_new;
	logic [AGE_W-1:0]           age_inc;
	logic [ADDR_W-1:0]          wi_next;
	logic [D_W-1:0]             diff;
	logic [D_W-1:0]             start_full;

	// window store
	weat_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_WINDOW)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept),
		.waddr(wi_q),
		.wdata(sample),
		.re   (cmd.scan_rd),
		.raddr(scan_addr_q),
		.rdata(rd_data)
	);

	// effective window length, clamped to one..store depth
	always_comb begin
		wl_ext = CMP_W'(wl_q);
		if (wl_q == '0) begin
			n = AGE_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			n = AGE_MAX;
		end else begin
			n = AGE_W'(wl_ext);
		end
	end

	// fast path of a new word and oldest slot of the window
	always_comb begin
		restart    = series_start || !active_q;
		take_new   = takes_over(kind_q, sample, ext_q);
		age_inc    = (age_q < AGE_MAX) ? AGE_W'(age_q + 1'b1) : age_q;
		wi_next    = (wi_q == LAST_ADDR) ? '0 : ADDR_W'(wi_q + 1'b1);
		diff       = D_W'(wi_next) - D_W'(n);
		start_full = diff[D_W-1] ? D_W'(diff + D_W'(MAX_WINDOW)) : diff;
	end

	// status towards the controller
	always_comb begin
		status.need_scan = !restart && !take_new && (age_inc >= n);
		status.scan_last = (k_q == '0);
		status.out_free  = !out_valid_q || out_ready;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= WL_RESET;
			kind_q <= KIND_HIGH;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: wl_q   <= cfg_data;
				REG_EXTREME_KIND:  kind_q <= cfg_data[0];
			endcase
		end
	end

	// tracked extreme, its age, write pointer and series flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q     <= '0;
			ext_q    <= '0;
			age_q    <= '0;
			active_q <= 1'b0;
		end else if (cmd.accept) begin
			wi_q     <= wi_next;
			active_q <= 1'b1;
			if (restart || take_new) begin
				ext_q <= sample;
				age_q <= '0;
			end else begin
				age_q <= age_inc;
			end
		end else if (rd_valid_s1) begin
			if (first_s1 || takes_over(kind_q, rd_data, ext_q)) begin
				ext_q <= rd_data;
				age_q <= AGE_W'(k_s1);
			end
		end
	end

	// rescan pointers, oldest entry first
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			scan_addr_q <= ADDR_W'(start_full);
			k_q         <= ADDR_W'(n - 1'b1);
			first_q     <= 1'b1;
		end else if (cmd.scan_rd) begin
			scan_addr_q <= (scan_addr_q == LAST_ADDR) ? '0 : ADDR_W'(scan_addr_q + 1'b1);
			k_q         <= ADDR_W'(k_q - 1'b1);
			first_q     <= 1'b0;
		end
		k_s1     <= k_q;
		first_s1 <= first_q;
	end

	// read data valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= OUT_W'(age_q);
		end
	end

	assign out_valid             = out_valid_q;
	assign samples_since_extreme = out_q;

	// read data only follows a read, and a finished rescan leaves the extreme in the window
	`WEAT_ASSERT_SAME(a_rd_follows, rd_valid_s1, $past(cmd.scan_rd))
	`WEAT_ASSERT_NEXT(a_scan_in_window, rd_valid_s1 && (k_s1 == '0), age_q < n)

endmodule
